>>> hdl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and codes of the positional list engine.
// ----------------------------------------------------------------------------
package plm_pkg;

  localparam int unsigned PosW = 11;

  typedef enum logic [2:0] {
    OpPush   = 3'd0,
    OpInsert = 3'd1,
    OpDelete = 3'd2,
    OpMove   = 3'd3,
    OpRead   = 3'd4
  } op_e;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNoEffect = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef enum logic [1:0] {
    SIdle,
    SPlan,
    SGather,
    SApply
  } state_e;

  typedef struct packed {
    logic            apply;
    logic            up;
    logic            down;
    logic            wr;
    logic [PosW-1:0] lo;
    logic [PosW-1:0] hi;
    logic [PosW-1:0] wpos;
  } shift_ctl_t;

endpackage

>>> hdl/plm_cmd_if.sv
// ----------------------------------------------------------------------------
// plm_cmd_if
// Command channel of the positional list engine.
// ----------------------------------------------------------------------------
interface plm_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [7:0]         index;
  logic [7:0]         to_index;
  logic signed [31:0] value;

  modport source (output valid, output op, output index, output to_index, output value,
                  input ready);
  modport sink (input valid, input op, input index, input to_index, input value,
                output ready);
endinterface

>>> hdl/plm_rsp_if.sv
// ----------------------------------------------------------------------------
// plm_rsp_if
// Result channel of the positional list engine.
// ----------------------------------------------------------------------------
interface plm_rsp_if;
  logic               valid;
  logic               ready;
  logic [7:0]         length;
  logic signed [31:0] read_value;
  logic [1:0]         status;

  modport source (output valid, output length, output read_value, output status,
                  input ready);
  modport sink (input valid, input length, input read_value, input status,
                output ready);
endinterface

>>> hdl/plm_cell.sv
// ----------------------------------------------------------------------------
// plm_cell
// One storage cell of the list: holds, loads the broadcast word, or takes
// the word of its left or right neighbor.
// ----------------------------------------------------------------------------
module plm_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                   clk_i,
  input  plm_pkg::shift_ctl_t    ctl_i,
  input  logic [31:0]            left_i,
  input  logic [31:0]            right_i,
  input  logic [31:0]            word_i,
  output logic [31:0]            val_o
);

  localparam int unsigned PW = plm_pkg::PosW;
  localparam logic [PW-1:0] Pos = PW'(POS);

  logic [31:0] val_d;
  logic [31:0] val_q;
  logic        in_range;

  assign in_range = (ctl_i.lo <= Pos) && (Pos <= ctl_i.hi);

  always_comb begin
    val_d = val_q;
    if (ctl_i.wr && (ctl_i.wpos == Pos)) begin
      val_d = word_i;
    end else if (ctl_i.up && in_range) begin
      val_d = left_i;
    end else if (ctl_i.down && in_range) begin
      val_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.apply) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

>>> hdl/plm_fetch.sv
// ----------------------------------------------------------------------------
// plm_fetch
// Two-level registered word select: pick one cell in each group, then
// pick the group.
// ----------------------------------------------------------------------------
module plm_fetch #(
  parameter int unsigned DEPTH = 128,
  localparam int unsigned PW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic [31:0]   cells_i [DEPTH],
  input  logic [PW-1:0] addr_i,
  output logic [31:0]   word_o
);

  localparam int unsigned LW = (PW < 4) ? PW : 4;
  localparam int unsigned G  = 1 << LW;
  localparam int unsigned NG = (DEPTH + G - 1) / G;

  logic [31:0]   lane_d [NG];
  logic [31:0]   lane_q [NG];
  logic [PW-1:0] addr_q;
  logic [31:0]   word_d;
  logic [31:0]   word_q;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      lane_d[g] = '0;
      for (int j = 0; j < G; j++) begin
        if (((g * G + j) < DEPTH) && (addr_i[LW-1:0] == LW'(j))) begin
          lane_d[g] = cells_i[((g * G + j) < DEPTH) ? (g * G + j) : 0];
        end
      end
    end
  end

  always_comb begin
    word_d = '0;
    for (int g = 0; g < NG; g++) begin
      if ((addr_q >> LW) == PW'(g)) begin
        word_d = lane_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    addr_q <= addr_i;
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

>>> hdl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH signed words with push, insert, delete, move
// and read commands, one result per command.
// ----------------------------------------------------------------------------
// A command's result is registered in the output register after these steps:
// plan the shift and select one cell per group, select the group, then update
// every cell of the chain at once, each taking its own, its neighbor's or the
// broadcast word. The update waits while an earlier result is still held. The
// two-level word select for read and move sets these steps; a new command is
// taken only after the previous one has updated the cells. A finished result
// waits in the output register while the next command is taken. The length
// field reports the element count modulo 256.
module positional_list_engine #(
  parameter int unsigned DEPTH = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  plm_cmd_if.sink         cmd_i,
  plm_rsp_if.source       rsp_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned XW   = ((CW > 8) ? CW : 8) + 1;
  localparam int unsigned PosW = plm_pkg::PosW;

  plm_pkg::state_e state_d, state_q;

  logic [2:0]  op_q;
  logic [7:0]  idx_q;
  logic [7:0]  dst_q;
  logic [31:0] val_q;

  logic [CW-1:0] count_q;

  plm_pkg::shift_ctl_t ctl_d, ctl_q, cell_ctl;
  logic [1:0]    st_d, st_q;
  logic [CW-1:0] len_d, len_q;
  logic          use_fetch_d, use_fetch_q;
  logic          rd_ok_d, rd_ok_q;
  logic [PW-1:0] faddr;

  logic [XW-1:0] idx_x, dst_x, cnt_x, dep_x, from_x, to_x, pos_x, len_x;

  logic [31:0] cell_val [DEPTH];
  logic [31:0] fetch_word;
  logic [31:0] cell_word;

  logic        rsp_valid_q;
  logic [7:0]  rsp_len_q;
  logic [31:0] rsp_rd_q;
  logic [1:0]  rsp_st_q;

  logic out_free;
  logic cmd_ready;
  logic plan_load;
  logic apply;

  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      plm_pkg::SIdle: begin
        if (cmd_i.valid) begin
          state_d = plm_pkg::SPlan;
        end
      end
      plm_pkg::SPlan:   state_d = plm_pkg::SGather;
      plm_pkg::SGather: state_d = plm_pkg::SApply;
      plm_pkg::SApply: begin
        if (out_free) begin
          state_d = plm_pkg::SIdle;
        end
      end
      default: state_d = plm_pkg::SIdle;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    plan_load = 1'b0;
    apply     = 1'b0;
    case (state_q)
      plm_pkg::SIdle:   cmd_ready = 1'b1;
      plm_pkg::SPlan:   plan_load = 1'b1;
      plm_pkg::SGather: ;
      plm_pkg::SApply:  apply = out_free;
      default: ;
    endcase
  end

  assign cmd_i.ready = cmd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plm_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_ready) begin
      op_q  <= cmd_i.op;
      idx_q <= cmd_i.index;
      dst_q <= cmd_i.to_index;
      val_q <= cmd_i.value;
    end
  end

  assign idx_x  = XW'(idx_q);
  assign dst_x  = XW'(dst_q);
  assign cnt_x  = XW'(count_q);
  assign dep_x  = XW'(DEPTH);
  assign from_x = (idx_x >= cnt_x) ? (cnt_x - XW'(1)) : idx_x;
  assign to_x   = (dst_x > cnt_x) ? cnt_x : dst_x;
  assign pos_x  = (plm_pkg::op_e'(op_q) == plm_pkg::OpPush) ? '0 :
                  ((idx_x > cnt_x) ? cnt_x : idx_x);

  always_comb begin
    ctl_d       = '0;
    st_d        = plm_pkg::StNoEffect;
    len_d       = count_q;
    use_fetch_d = 1'b0;
    rd_ok_d     = 1'b0;
    faddr       = PW'(idx_x);
    case (plm_pkg::op_e'(op_q))
      plm_pkg::OpPush, plm_pkg::OpInsert: begin
        if (cnt_x >= dep_x) begin
          st_d = plm_pkg::StFull;
        end else begin
          ctl_d.up   = 1'b1;
          ctl_d.wr   = 1'b1;
          ctl_d.lo   = PosW'(pos_x + XW'(1));
          ctl_d.hi   = PosW'(cnt_x);
          ctl_d.wpos = PosW'(pos_x);
          len_d      = count_q + CW'(1);
          st_d       = plm_pkg::StDone;
        end
      end
      plm_pkg::OpDelete: begin
        if (idx_x < cnt_x) begin
          ctl_d.down = 1'b1;
          ctl_d.lo   = PosW'(idx_x);
          ctl_d.hi   = PosW'(cnt_x - XW'(1));
          len_d      = count_q - CW'(1);
          st_d       = plm_pkg::StDone;
        end
      end
      plm_pkg::OpMove: begin
        faddr = PW'(from_x);
        if ((cnt_x >= XW'(2)) && (from_x != to_x) && ((from_x + XW'(1)) != to_x)) begin
          ctl_d.wr    = 1'b1;
          use_fetch_d = 1'b1;
          st_d        = plm_pkg::StDone;
          if (from_x < to_x) begin
            ctl_d.down = 1'b1;
            ctl_d.lo   = PosW'(from_x);
            ctl_d.hi   = PosW'(to_x - XW'(2));
            ctl_d.wpos = PosW'(to_x - XW'(1));
          end else begin
            ctl_d.up   = 1'b1;
            ctl_d.lo   = PosW'(to_x + XW'(1));
            ctl_d.hi   = PosW'(from_x);
            ctl_d.wpos = PosW'(to_x);
          end
        end
      end
      plm_pkg::OpRead: begin
        if (idx_x < cnt_x) begin
          rd_ok_d = 1'b1;
          st_d    = plm_pkg::StDone;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (plan_load) begin
      ctl_q       <= ctl_d;
      st_q        <= st_d;
      len_q       <= len_d;
      use_fetch_q <= use_fetch_d;
      rd_ok_q     <= rd_ok_d;
    end
  end

  always_comb begin
    cell_ctl       = ctl_q;
    cell_ctl.apply = apply;
  end

  assign cell_word = use_fetch_q ? fetch_word : val_q;

  plm_fetch #(
    .DEPTH (DEPTH)
  ) u_fetch (
    .clk_i   (clk_i),
    .cells_i (cell_val),
    .addr_i  (faddr),
    .word_o  (fetch_word)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [31:0] left_w;
    logic [31:0] right_w;

    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_val[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_val[k+1];
    end

    plm_cell #(
      .POS (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .word_i  (cell_word),
      .val_o   (cell_val[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (apply) begin
      count_q <= len_q;
    end
  end

  assign len_x = XW'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (apply) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      rsp_len_q <= len_x[7:0];
      rsp_rd_q  <= rd_ok_q ? fetch_word : '0;
      rsp_st_q  <= st_q;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.length     = rsp_len_q;
  assign rsp_o.read_value = $signed(rsp_rd_q);
  assign rsp_o.status     = rsp_st_q;

endmodule

>>> hdl/plm_checker.sv
// ----------------------------------------------------------------------------
// plm_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module plm_checker #(
  parameter int unsigned DEPTH = 128
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cmd_valid_i,
  input logic        cmd_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [7:0]  rsp_length_i,
  input logic [31:0] rsp_read_value_i,
  input logic [1:0]  rsp_status_i
);

  a_rsp_valid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_rsp_payload_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_length_i) && $stable(rsp_read_value_i) && $stable(rsp_status_i))
    else $error("result payload changed while stalled");

  a_busy_after_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command taken while previous one in flight");

  a_full_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == plm_pkg::StFull) |-> rsp_length_i == 8'(DEPTH))
    else $error("full status with list not full");

  a_read_value_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_read_value_i != '0) |-> rsp_status_i == plm_pkg::StDone)
    else $error("nonzero read value without done status");

endmodule

bind positional_list_engine plm_checker #(
  .DEPTH (DEPTH)
) u_plm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cmd_valid_i      (cmd_i.valid),
  .cmd_ready_i      (cmd_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_length_i     (rsp_o.length),
  .rsp_read_value_i (rsp_o.read_value),
  .rsp_status_i     (rsp_o.status)
);
